### hdl/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg
// Beat types, codes and fixed-point constants for the motion stall detector.
// ----------------------------------------------------------------------------
package msd_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MOVING_SPEED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLACEMENT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_MOTION  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVITY      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMPACT        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GRACE         = 3'd6;

    // item kinds
    localparam logic [1:0] ACT_IMU     = 2'd0;
    localparam logic [1:0] ACT_TICK    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // stall report codes
    localparam logic [1:0] REP_NONE    = 2'd0;
    localparam logic [1:0] REP_CLEARED = 2'd1;
    localparam logic [1:0] REP_FORWARD = 2'd2;
    localparam logic [1:0] REP_REVERSE = 2'd3;

    // stall cause codes
    localparam logic [2:0] CAUSE_NONE     = 3'd0;
    localparam logic [2:0] CAUSE_IMPACT   = 3'd1;
    localparam logic [2:0] CAUSE_OBSTACLE = 3'd2;
    localparam logic [2:0] CAUSE_DEAD     = 3'd3;
    localparam logic [2:0] CAUSE_SLIP     = 3'd4;
    localparam logic [2:0] CAUSE_NO_DISP  = 3'd5;
    localparam logic [2:0] CAUSE_HELD_OFF = 3'd6;

    // averaging: bias by 1/512, activity by 3277/65536
    localparam int         BIAS_SHIFT = 9;
    localparam int         ACT_SHIFT  = 16;
    localparam logic [12:0] ACT_GAIN  = 13'd3277;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] accel_x;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [11:0]        command_speed_abs;
        logic [11:0]        wheel_speed_abs;
        logic               obstacle_block;
        logic               reversing;
    } in_t;

    typedef struct packed {
        logic [1:0]  stall_report;
        logic [2:0]  cause_code;
        logic        is_stalled;
        logic [15:0] activity_level;
    } out_t;

endpackage

### hdl/motion_stall_detector.sv
// ----------------------------------------------------------------------------
// motion_stall_detector
// Stall watch for a driving car, fed by IMU samples, control ticks and plan
// restarts, with one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage
//   in channel (in_valid/in_ready/in_data): one beat is an IMU sample, a
//   control tick or a plan restart, chosen by in_data.action.
//   out channel (out_valid/out_ready/out_data): exactly one beat per input
//   beat, in order.
//   cfg port: cfg_wr_en writes cfg_data into register cfg_index at once;
//   write only while the block is idle.
// Timing
//   in_ready is high only while the sequencer is idle. An IMU beat runs
//   the bias, dyn, mul and act states, a tick diff, mx, my, mt and dec,
//   a restart the restart state, and an unused action code none; each then
//   ends in push. The multiplier makes one pass for the activity gain and
//   three for a tick: the squared x and y offsets and the squared threshold.
// Reset and stalls
//   rst_n clears all averages, counters, flags and the output register and
//   loads the register defaults; the grace window starts as after a restart.
//   A result waits in the output register while out_ready is low; the next
//   input beat can still be taken and worked on, and its result is held
//   back until the register is free.
// ----------------------------------------------------------------------------
module motion_stall_detector (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  msd_pkg::in_t                    in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output msd_pkg::out_t                   out_data,
    input  logic                            cfg_wr_en,
    input  logic [msd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [msd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import msd_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_BIAS    = 4'd1;
    localparam logic [3:0] ST_DYN     = 4'd2;
    localparam logic [3:0] ST_MUL     = 4'd3;
    localparam logic [3:0] ST_ACT     = 4'd4;
    localparam logic [3:0] ST_DIFF    = 4'd5;
    localparam logic [3:0] ST_MX      = 4'd6;
    localparam logic [3:0] ST_MY      = 4'd7;
    localparam logic [3:0] ST_MT      = 4'd8;
    localparam logic [3:0] ST_DEC     = 4'd9;
    localparam logic [3:0] ST_RESTART = 4'd10;
    localparam logic [3:0] ST_PUSH    = 4'd11;

    function automatic logic [15:0] inc_sat(input logic [15:0] c);
        return (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

    // configuration registers
    logic [11:0] speed_thr_reg;
    logic [15:0] timeout_reg;
    logic [11:0] disp_thr_reg;
    logic [11:0] wheel_thr_reg;
    logic [14:0] act_thr_reg;
    logic [14:0] impact_thr_reg;
    logic [15:0] grace_reg;

    // block state
    logic [3:0]         state_reg, state_next;
    logic signed [31:0] bias_reg;
    logic [31:0]        act_reg;
    logic [15:0]        peak_reg;
    logic               armed_reg;
    logic               latched_reg;
    logic signed [23:0] anchor_x_reg, anchor_y_reg;
    logic [15:0]        elapsed_reg, idle_reg, since_reg;
    logic [1:0]         report_reg;
    logic [2:0]         cause_reg;
    logic               out_valid_reg;
    out_t               out_reg;

    // working registers
    in_t                item_reg;
    logic [32:0]        dyn_reg;
    logic signed [24:0] dx_reg, dy_reg;
    logic signed [58:0] prod_reg;
    logic [49:0]        d2_reg;

    logic               push_ok;

    // ---------------- imu datapath ----------------
    logic signed [31:0] a16;
    logic signed [32:0] bias_diff, bias_step, bias_sum;
    logic [32:0]        dyn_abs;
    logic signed [33:0] act_diff;
    logic signed [58:0] act_step;
    logic signed [44:0] act_sum;
    logic [31:0]        act_new;
    logic [15:0]        pk16;

    always_comb
    begin
        a16       = {item_reg.accel_x, 16'h0000};
        bias_diff = {a16[31], a16} - {bias_reg[31], bias_reg};
        bias_step = bias_diff >>> BIAS_SHIFT;
        bias_sum  = {bias_reg[31], bias_reg} + bias_step;
        // after the bias update the same difference is the residual
        dyn_abs   = bias_diff[32] ? 33'(-bias_diff) : 33'(bias_diff);
        act_diff  = {1'b0, dyn_reg} - {2'b00, act_reg};
        act_step  = prod_reg >>> ACT_SHIFT;
        act_sum   = {13'd0, act_reg} + act_step[44:0];
        if (act_sum[44])
            act_new = 32'd0;
        else if (|act_sum[43:32])
            act_new = 32'hFFFF_FFFF;
        else
            act_new = act_sum[31:0];
        pk16 = dyn_reg[32] ? 16'hFFFF : dyn_reg[31:16];
    end

    // ---------------- shared multiplier ----------------
    logic signed [33:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [58:0] prod_next;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL:
            begin
                mul_a = act_diff;
                mul_b = {12'd0, ACT_GAIN};
            end
            ST_MX:
            begin
                mul_a = 34'(dx_reg);
                mul_b = dx_reg;
            end
            ST_MY:
            begin
                mul_a = 34'(dy_reg);
                mul_b = dy_reg;
            end
            ST_MT:
            begin
                mul_a = {22'd0, disp_thr_reg};
                mul_b = {13'd0, disp_thr_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // ---------------- tick decision ----------------
    logic        grace, moving, turning, far, quiet, disp_hit, tick_stall, watching;
    logic [15:0] el_inc, idle_inc;
    logic [2:0]  tick_cause;

    always_comb
    begin
        grace    = since_reg < grace_reg;
        moving   = item_reg.command_speed_abs >= speed_thr_reg;
        turning  = item_reg.wheel_speed_abs >= wheel_thr_reg;
        far      = d2_reg > {26'd0, prod_reg[23:0]};
        quiet    = act_reg < {1'b0, act_thr_reg, 16'h0000};
        el_inc   = inc_sat(elapsed_reg);
        idle_inc = turning ? 16'd0 : inc_sat(idle_reg);
        watching = !latched_reg && moving && !grace && armed_reg;
        disp_hit   = 1'b0;
        tick_cause = CAUSE_NONE;
        if (peak_reg > {1'b0, impact_thr_reg})
            tick_cause = CAUSE_IMPACT;
        else if (idle_inc > timeout_reg)
            tick_cause = item_reg.obstacle_block ? CAUSE_OBSTACLE : CAUSE_DEAD;
        else if (far)
            disp_hit = 1'b1;
        else if (el_inc > timeout_reg)
            tick_cause = quiet ? (turning ? CAUSE_SLIP : CAUSE_NO_DISP) : CAUSE_HELD_OFF;
        tick_stall = (tick_cause != CAUSE_NONE) && (tick_cause != CAUSE_HELD_OFF);
    end

    // ---------------- sequencer ----------------
    assign in_ready = (state_reg == ST_IDLE);
    assign push_ok  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_data.action)
                        ACT_IMU:     state_next = ST_BIAS;
                        ACT_TICK:    state_next = ST_DIFF;
                        ACT_RESTART: state_next = ST_RESTART;
                        default:     state_next = ST_PUSH;
                    endcase
                end
            end
            ST_BIAS:    state_next = ST_DYN;
            ST_DYN:     state_next = ST_MUL;
            ST_MUL:     state_next = ST_ACT;
            ST_ACT:     state_next = ST_PUSH;
            ST_DIFF:    state_next = ST_MX;
            ST_MX:      state_next = ST_MY;
            ST_MY:      state_next = ST_MT;
            ST_MT:      state_next = ST_DEC;
            ST_DEC:     state_next = ST_PUSH;
            ST_RESTART: state_next = ST_PUSH;
            ST_PUSH:    state_next = push_ok ? ST_IDLE : ST_PUSH;
            default:    state_next = ST_IDLE;
        endcase
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (in_valid && in_ready)
            item_reg <= in_data;
        if (state_reg == ST_DYN)
            dyn_reg <= dyn_abs;
        if (state_reg == ST_DIFF)
        begin
            dx_reg <= {item_reg.pos_x[23], item_reg.pos_x} - {anchor_x_reg[23], anchor_x_reg};
            dy_reg <= {item_reg.pos_y[23], item_reg.pos_y} - {anchor_y_reg[23], anchor_y_reg};
        end
        if (state_reg == ST_MY)
            d2_reg <= prod_reg[49:0];
        else if (state_reg == ST_MT)
            d2_reg <= d2_reg + prod_reg[49:0];
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_thr_reg  <= 12'd150;
            timeout_reg    <= 16'd75;
            disp_thr_reg   <= 12'd50;
            wheel_thr_reg  <= 12'd20;
            act_thr_reg    <= 15'd51;
            impact_thr_reg <= 15'd3072;
            grace_reg      <= 16'd50;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MOVING_SPEED:  speed_thr_reg  <= cfg_data[11:0];
                REG_STALL_TIMEOUT: timeout_reg    <= cfg_data;
                REG_DISPLACEMENT:  disp_thr_reg   <= cfg_data[11:0];
                REG_WHEEL_MOTION:  wheel_thr_reg  <= cfg_data[11:0];
                REG_ACTIVITY:      act_thr_reg    <= cfg_data[14:0];
                REG_IMPACT:        impact_thr_reg <= cfg_data[14:0];
                REG_GRACE:         grace_reg      <= cfg_data;
                default:           ;
            endcase
        end
    end

    // block state and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bias_reg      <= '0;
            act_reg       <= '0;
            peak_reg      <= '0;
            armed_reg     <= 1'b0;
            latched_reg   <= 1'b0;
            anchor_x_reg  <= '0;
            anchor_y_reg  <= '0;
            elapsed_reg   <= '0;
            idle_reg      <= '0;
            since_reg     <= '0;
            report_reg    <= REP_NONE;
            cause_reg     <= CAUSE_NONE;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // in push the output register is reloaded below instead
            if (out_valid_reg && out_ready && state_reg != ST_PUSH)
                out_valid_reg <= 1'b0;

            if (in_valid && in_ready)
            begin
                report_reg <= REP_NONE;
                cause_reg  <= CAUSE_NONE;
            end

            case (state_reg)
                ST_BIAS:
                    bias_reg <= bias_sum[31:0];
                ST_ACT:
                begin
                    act_reg <= act_new;
                    if (pk16 > peak_reg)
                        peak_reg <= pk16;
                end
                ST_DEC:
                begin
                    since_reg <= inc_sat(since_reg);
                    if (!latched_reg)
                    begin
                        peak_reg <= '0;
                        if (moving && !grace)
                        begin
                            if (!armed_reg)
                            begin
                                anchor_x_reg <= item_reg.pos_x;
                                anchor_y_reg <= item_reg.pos_y;
                                elapsed_reg  <= '0;
                                idle_reg     <= '0;
                                armed_reg    <= 1'b1;
                            end
                            else
                            begin
                                idle_reg    <= idle_inc;
                                elapsed_reg <= disp_hit ? 16'd0 : el_inc;
                                // progress made: rearm the anchor here
                                if (disp_hit)
                                begin
                                    anchor_x_reg <= item_reg.pos_x;
                                    anchor_y_reg <= item_reg.pos_y;
                                end
                                if (tick_stall)
                                    latched_reg <= 1'b1;
                            end
                        end
                        else
                            armed_reg <= 1'b0;
                    end
                    cause_reg  <= watching ? tick_cause : CAUSE_NONE;
                    report_reg <= (watching && tick_stall)
                                  ? (item_reg.reversing ? REP_REVERSE : REP_FORWARD)
                                  : REP_NONE;
                end
                ST_RESTART:
                begin
                    report_reg  <= latched_reg ? REP_CLEARED : REP_NONE;
                    latched_reg <= 1'b0;
                    armed_reg   <= 1'b0;
                    since_reg   <= '0;
                end
                ST_PUSH:
                begin
                    if (push_ok)
                    begin
                        out_reg.stall_report   <= report_reg;
                        out_reg.cause_code     <= cause_reg;
                        out_reg.is_stalled     <= latched_reg;
                        out_reg.activity_level <= act_reg[31:16];
                        out_valid_reg          <= 1'b1;
                    end
                end
                default:
                    ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ---------------- assertions ----------------
    // a stall only latches from a tick decision
    a_latch_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(latched_reg) |-> $past(state_reg) == ST_DEC)
        else $error("stall latched outside a tick decision");

    // a result waiting in push is never dropped
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH && push_ok) |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("result beat not loaded into output register");

    // a stall report comes with a latched stall and a real cause
    a_stall_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.stall_report == REP_FORWARD
                           || out_reg.stall_report == REP_REVERSE))
        |-> out_reg.is_stalled && out_reg.cause_code != CAUSE_NONE
            && out_reg.cause_code != CAUSE_HELD_OFF)
        else $error("stall report without latched stall or cause");

    // a held-off timeout never reports a stall
    a_held_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.cause_code == CAUSE_HELD_OFF)
        |-> out_reg.stall_report == REP_NONE)
        else $error("held-off timeout reported as stall");

    // a cleared stall leaves nothing latched
    a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.stall_report == REP_CLEARED)
        |-> !out_reg.is_stalled && out_reg.cause_code == CAUSE_NONE)
        else $error("cleared report with stall still latched");

endmodule
